@@ rtl/pss_pkg.sv @@
// Shared types and constants for the periodic stream scheduler.
// Used by every module of the block; depends on nothing.
package pss_pkg;

	localparam int ID_W      = 4;
	localparam int CMD_W     = 4;
	localparam int RATE_W    = 16;
	localparam int QUEUED_W  = 8;
	localparam int SLOT_W    = 4;
	localparam int MASK_W    = 15;
	localparam int ACTIVE_W  = 16;

	localparam logic [MASK_W-1:0] MASK_RESET = 15'd3976;

	typedef enum logic [2:0] {
		K_ADD    = 3'd0,
		K_REMOVE = 3'd1,
		K_TICK   = 3'd2,
		K_POLL   = 3'd3,
		K_QUERY  = 3'd4,
		K_FAIL   = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		STS_OK          = 4'd0,
		STS_UNKNOWN_CMD = 4'd1,
		STS_NOT_STREAM  = 4'd2,
		STS_ID_ZERO     = 4'd3,
		STS_ID_INVALID  = 4'd4,
		STS_IN_USE      = 4'd5,
		STS_FULL        = 4'd6,
		STS_NO_SLOT     = 4'd7,
		STS_NOT_FOUND   = 4'd8,
		STS_MISMATCH    = 4'd9,
		STS_NOTHING_DUE = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [CMD_W-1:0]    cmd;
		logic [RATE_W-1:0]   rate;
		logic [RATE_W-1:0]   cd;
		logic [QUEUED_W-1:0] queued;
		logic                has_args;
		logic [SLOT_W-1:0]   slot;
	} entry_t;

	typedef struct packed {
		logic   en_id;
		logic   en_static;
		logic   en_dyn;
		entry_t ent;
	} tbl_wr_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        id;
		logic [RATE_W-1:0] rate;
		logic              found;
	} step_req_t;

	typedef struct packed {
		logic                active;
		logic                id_match;
		logic                rate_match;
		logic                hit;
		logic                wb_en;
		logic [RATE_W-1:0]   wb_cd;
		logic [QUEUED_W-1:0] wb_queued;
	} step_res_t;

endpackage

@@ rtl/pss_table.sv @@
// Stream table storage: one read port at the scan index, one write port.
// Depends on pss_pkg for the entry and write request types.
module pss_table #(
	parameter int TABLE_ENTRIES = 4,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [IDX_W-1:0]                  rd_idx,
	output pss_pkg::entry_t                   rd_ent,
	input  logic [IDX_W-1:0]                  wr_idx,
	input  pss_pkg::tbl_wr_t                  wr,
	output logic [pss_pkg::ACTIVE_W-1:0]      active_mask
);

	logic [pss_pkg::ID_W-1:0]     id_q     [TABLE_ENTRIES];
	logic [pss_pkg::CMD_W-1:0]    cmd_q    [TABLE_ENTRIES];
	logic [pss_pkg::RATE_W-1:0]   rate_q   [TABLE_ENTRIES];
	logic [pss_pkg::RATE_W-1:0]   cd_q     [TABLE_ENTRIES];
	logic [pss_pkg::QUEUED_W-1:0] queued_q [TABLE_ENTRIES];
	logic                         args_q   [TABLE_ENTRIES];
	logic [pss_pkg::SLOT_W-1:0]   slot_q   [TABLE_ENTRIES];

	// id of zero marks a free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < TABLE_ENTRIES; e++) begin
				id_q[e] <= '0;
			end
		end else if (wr.en_id) begin
			id_q[wr_idx] <= wr.ent.id;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en_static) begin
			cmd_q[wr_idx]  <= wr.ent.cmd;
			rate_q[wr_idx] <= wr.ent.rate;
			args_q[wr_idx] <= wr.ent.has_args;
			slot_q[wr_idx] <= wr.ent.slot;
		end
		if (wr.en_dyn) begin
			cd_q[wr_idx]     <= wr.ent.cd;
			queued_q[wr_idx] <= wr.ent.queued;
		end
	end

	always_comb begin
		rd_ent.id       = id_q[rd_idx];
		rd_ent.cmd      = cmd_q[rd_idx];
		rd_ent.rate     = rate_q[rd_idx];
		rd_ent.cd       = cd_q[rd_idx];
		rd_ent.queued   = queued_q[rd_idx];
		rd_ent.has_args = args_q[rd_idx];
		rd_ent.slot     = slot_q[rd_idx];
	end

	always_comb begin
		active_mask = '0;
		for (int e = 0; e < TABLE_ENTRIES; e++) begin
			if (id_q[e] != '0) begin
				active_mask[id_q[e]] = 1'b1;
			end
		end
	end

endmodule

@@ rtl/pss_step_unit.sv @@
// Shared per-entry unit: id and rate compare, countdown and queue arithmetic.
// Depends on pss_pkg for the entry, request and result types.
module pss_step_unit (
	input  pss_pkg::entry_t   ent,
	input  pss_pkg::step_req_t req,
	output pss_pkg::step_res_t res
);

	logic [pss_pkg::RATE_W-1:0] cd_dec;

	assign cd_dec = ent.cd - 16'd1;

	always_comb begin
		res            = '0;
		res.active     = (ent.id != '0);
		res.id_match   = res.active && (req.id[7:4] == 4'd0) && (ent.id == req.id[3:0]);
		res.rate_match = res.active && (ent.rate == req.rate);
		res.hit        = res.active && (ent.queued != '0) && !req.found;
		res.wb_cd      = ent.cd;
		res.wb_queued  = ent.queued;
		case (req.kind)
			pss_pkg::K_TICK: begin
				res.wb_en = res.active;
				// reload on expiry and queue one run
				if (cd_dec == '0) begin
					res.wb_cd     = ent.rate;
					res.wb_queued = ent.queued + 8'd1;
				end else begin
					res.wb_cd = cd_dec;
				end
			end
			pss_pkg::K_POLL: begin
				res.wb_en     = res.hit;
				res.wb_queued = ent.queued - 8'd1;
			end
			default: begin
				res.wb_en = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/pss_ctrl.sv @@
// Sequencer: request latch, table scan, commit decision, slot map and result register.
// Depends on pss_pkg; drives pss_table and pss_step_unit through their structs.
module pss_ctrl #(
	parameter int TABLE_ENTRIES = 4,
	parameter int ARG_SLOTS     = 8,
	parameter int COMMANDS      = 15,
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pss_pkg::MASK_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      kind,
	input  logic [7:0]                      strm_id,
	input  logic [15:0]                     rate,
	input  logic                            cmd_found,
	input  logic [3:0]                      cmd_sel,
	input  logic                            has_args,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [3:0]                      status,
	output logic [3:0]                      fire_id,
	output logic [3:0]                      fire_cmd,
	output logic                            fire_has_args,
	output logic [2:0]                      fire_slot,
	output logic [15:0]                     query_rate,
	output logic [15:0]                     active_mask,
	output logic [IDX_W-1:0]                rd_idx,
	input  pss_pkg::entry_t                 rd_ent,
	output logic [IDX_W-1:0]                wr_idx,
	output pss_pkg::tbl_wr_t                wr,
	input  logic [pss_pkg::ACTIVE_W-1:0]    tbl_mask,
	output pss_pkg::step_req_t              step_req,
	input  pss_pkg::step_res_t              step_res
);

	pss_pkg::state_t state_q, state_d;

	logic [pss_pkg::MASK_W-1:0]  smask_q;
	logic [ARG_SLOTS-1:0]        slot_busy_q, slot_busy_d;

	pss_pkg::kind_t              req_kind_q;
	logic [7:0]                  req_id_q;
	logic [pss_pkg::RATE_W-1:0]  rate_q;
	logic                        cmd_found_q;
	logic [pss_pkg::CMD_W-1:0]   cmd_q;
	logic                        args_q;

	logic [IDX_W-1:0]            scan_idx_q;
	logic                        found_q;
	logic [IDX_W-1:0]            found_idx_q;
	pss_pkg::entry_t             found_ent_q;
	logic                        dup_q;
	logic                        free_ok_q;
	logic [IDX_W-1:0]            free_idx_q;
	logic [pss_pkg::RATE_W-1:0]  copy_cd_q;

	pss_pkg::status_t            status_q;
	logic                        rep_q;

	logic                        out_valid_q;
	pss_pkg::status_t            out_status_q;
	pss_pkg::entry_t             out_ent_q;
	logic [pss_pkg::ACTIVE_W-1:0] out_mask_q;

	logic                        accept;
	logic                        scanning;
	logic                        committing;
	logic                        load_out;
	logic                        last_idx;

	pss_pkg::status_t            c_status;
	logic                        c_add;
	logic                        c_free;
	logic                        c_rep;
	logic                        free_slot_ok;
	logic [pss_pkg::SLOT_W-1:0]  free_slot;
	logic [15:0]                 smask_ext;

	assign smask_ext = {1'b0, smask_q};
	assign last_idx  = (scan_idx_q == IDX_W'(TABLE_ENTRIES - 1));

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pss_pkg::S_IDLE: begin
				if (in_valid) state_d = pss_pkg::S_SCAN;
			end
			pss_pkg::S_SCAN: begin
				if (last_idx) state_d = pss_pkg::S_COMMIT;
			end
			pss_pkg::S_COMMIT: begin
				state_d = pss_pkg::S_FINISH;
			end
			pss_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) state_d = pss_pkg::S_IDLE;
			end
			default: begin
				state_d = pss_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		scanning   = 1'b0;
		committing = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			pss_pkg::S_IDLE:   in_ready   = 1'b1;
			pss_pkg::S_SCAN:   scanning   = 1'b1;
			pss_pkg::S_COMMIT: committing = 1'b1;
			pss_pkg::S_FINISH: load_out   = !out_valid_q || out_ready;
			default:           in_ready   = 1'b0;
		endcase
	end

	assign accept = in_valid && in_ready;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smask_q <= pss_pkg::MASK_RESET;
		end else if (cfg_we) begin
			smask_q <= cfg_wdata;
		end
	end

	// ---------------- shared unit hookup ----------------
	assign rd_idx         = scan_idx_q;
	assign step_req.kind  = req_kind_q;
	assign step_req.id    = req_id_q;
	assign step_req.rate  = rate_q;
	assign step_req.found = found_q;

	// ---------------- request latch and scan ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			req_kind_q  <= pss_pkg::kind_t'(kind);
			req_id_q    <= strm_id;
			rate_q      <= (rate == 16'd0) ? 16'd1 : rate;
			copy_cd_q   <= (rate == 16'd0) ? 16'd1 : rate;
			cmd_found_q <= cmd_found;
			cmd_q       <= cmd_sel;
			args_q      <= has_args;
			scan_idx_q  <= '0;
			found_q     <= 1'b0;
			dup_q       <= 1'b0;
			free_ok_q   <= 1'b0;
		end else if (scanning) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			case (req_kind_q)
				pss_pkg::K_ADD: begin
					if (step_res.id_match) dup_q <= 1'b1;
					// the last active entry with the same rate wins
					if (step_res.rate_match) copy_cd_q <= rd_ent.cd;
					if (!step_res.active && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= scan_idx_q;
					end
				end
				pss_pkg::K_REMOVE, pss_pkg::K_QUERY, pss_pkg::K_FAIL: begin
					if (step_res.id_match && !found_q) begin
						found_q     <= 1'b1;
						found_idx_q <= scan_idx_q;
						found_ent_q <= rd_ent;
					end
				end
				pss_pkg::K_POLL: begin
					if (step_res.hit) begin
						found_q     <= 1'b1;
						found_idx_q <= scan_idx_q;
						found_ent_q <= rd_ent;
					end
				end
				default: begin
				end
			endcase
		end
		if (committing) begin
			status_q <= c_status;
			rep_q    <= c_rep;
		end
	end

	// ---------------- commit decision ----------------
	always_comb begin
		free_slot_ok = 1'b0;
		free_slot    = '0;
		for (int i = ARG_SLOTS - 1; i >= 0; i--) begin
			if (!slot_busy_q[i]) begin
				free_slot_ok = 1'b1;
				free_slot    = pss_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		c_status = pss_pkg::STS_OK;
		c_add    = 1'b0;
		c_free   = 1'b0;
		c_rep    = 1'b0;
		case (req_kind_q)
			pss_pkg::K_ADD: begin
				if (!cmd_found_q || ({1'b0, cmd_q} >= 5'(COMMANDS)))
					c_status = pss_pkg::STS_UNKNOWN_CMD;
				else if (!smask_ext[cmd_q])
					c_status = pss_pkg::STS_NOT_STREAM;
				else if (req_id_q == 8'd0)
					c_status = pss_pkg::STS_ID_ZERO;
				else if (req_id_q[7:4] != 4'd0)
					c_status = pss_pkg::STS_ID_INVALID;
				else if (dup_q)
					c_status = pss_pkg::STS_IN_USE;
				else if (!free_ok_q)
					c_status = pss_pkg::STS_FULL;
				else if (args_q && !free_slot_ok)
					c_status = pss_pkg::STS_NO_SLOT;
				else
					c_add = 1'b1;
			end
			pss_pkg::K_REMOVE: begin
				if (req_id_q == 8'd0)
					c_status = pss_pkg::STS_ID_ZERO;
				else if (!found_q)
					c_status = pss_pkg::STS_NOT_FOUND;
				else if (!cmd_found_q || (cmd_q != found_ent_q.cmd))
					c_status = pss_pkg::STS_MISMATCH;
				else
					c_free = 1'b1;
			end
			pss_pkg::K_POLL: begin
				if (found_q) c_rep = 1'b1;
				else c_status = pss_pkg::STS_NOTHING_DUE;
			end
			pss_pkg::K_QUERY: begin
				if (req_id_q == 8'd0)
					c_status = pss_pkg::STS_ID_ZERO;
				else if (!found_q)
					c_status = pss_pkg::STS_NOT_FOUND;
				else
					c_rep = 1'b1;
			end
			pss_pkg::K_FAIL: begin
				if (req_id_q == 8'd0)
					c_status = pss_pkg::STS_ID_ZERO;
				else if (!found_q)
					c_status = pss_pkg::STS_NOT_FOUND;
				else
					c_free = 1'b1;
			end
			default: begin
				c_status = pss_pkg::STS_OK;
			end
		endcase
	end

	// ---------------- table write port ----------------
	always_comb begin
		wr     = '0;
		wr_idx = scan_idx_q;
		if (scanning && step_res.wb_en) begin
			wr.en_dyn     = 1'b1;
			wr.ent.cd     = step_res.wb_cd;
			wr.ent.queued = step_res.wb_queued;
		end else if (committing && c_add) begin
			wr_idx           = free_idx_q;
			wr.en_id         = 1'b1;
			wr.en_static     = 1'b1;
			wr.en_dyn        = 1'b1;
			wr.ent.id        = req_id_q[3:0];
			wr.ent.cmd       = cmd_q;
			wr.ent.rate      = rate_q;
			wr.ent.cd        = copy_cd_q;
			wr.ent.queued    = '0;
			wr.ent.has_args  = args_q;
			wr.ent.slot      = args_q ? free_slot : '0;
		end else if (committing && c_free) begin
			wr_idx   = found_idx_q;
			wr.en_id = 1'b1;
		end
	end

	// ---------------- argument slots ----------------
	always_comb begin
		slot_busy_d = slot_busy_q;
		for (int i = 0; i < ARG_SLOTS; i++) begin
			if (committing && c_add && args_q && (free_slot == pss_pkg::SLOT_W'(i)))
				slot_busy_d[i] = 1'b1;
			if (committing && c_free && found_ent_q.has_args &&
			    (found_ent_q.slot == pss_pkg::SLOT_W'(i)))
				slot_busy_d[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_busy_q <= '0;
		end else begin
			slot_busy_q <= slot_busy_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_ent_q    <= rep_q ? found_ent_q : '0;
			out_mask_q   <= tbl_mask;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign fire_id       = out_ent_q.id;
	assign fire_cmd      = out_ent_q.cmd;
	assign fire_has_args = out_ent_q.has_args;
	assign fire_slot     = out_ent_q.slot[2:0];
	assign query_rate    = out_ent_q.rate;
	assign active_mask   = out_mask_q;

`ifndef SYNTH
	a_slots_le_streams: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_busy_q) <= $countones(tbl_mask))
		else $error("more argument slots busy than active streams");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pss_pkg::S_FINISH))
		else $error("result appeared outside the finish step");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pss_pkg::S_SCAN) && last_idx |=> (state_q == pss_pkg::S_COMMIT))
		else $error("scan did not end at the last entry");

	a_report_active: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && rep_q |-> (out_ent_q.id != '0))
		else $error("reported stream has a zero id");
`endif

endmodule

@@ rtl/periodic_stream_scheduler_top.sv @@
// Top level of the periodic stream scheduler.
// Depends on pss_pkg, pss_table, pss_step_unit and pss_ctrl.
//
// Usage:
//   Requests enter on in_valid/in_ready with kind, strm_id, rate, cmd_found,
//   cmd_sel and has_args; a request is taken at an edge where both are high.
//   Every request produces exactly one result on out_valid/out_ready carrying
//   status, fire_id, fire_cmd, fire_has_args, fire_slot, query_rate and the
//   active_mask taken after the request.
//   cfg_we/cfg_wdata write the streamable command mask; write it only while
//   no request is in flight.
// Timing:
//   A request is taken in the idle step, then the sequencer walks the table
//   one entry per cycle through the shared compare/arithmetic unit, commits
//   and then loads the result register in the finish step. No new request is
//   taken until the result register is loaded and the sequencer is back in
//   idle. A stalled receiver holds the finish step while the result register
//   is still full and unread. Reset clears the table, frees every argument
//   slot, restores the default mask and drops any pending result.
module periodic_stream_scheduler_top #(
	parameter int TABLE_ENTRIES = 4,
	parameter int ARG_SLOTS     = 8,
	parameter int COMMANDS      = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  strm_id,
	input  logic [15:0] rate,
	input  logic        cmd_found,
	input  logic [3:0]  cmd_sel,
	input  logic        has_args,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [3:0]  fire_id,
	output logic [3:0]  fire_cmd,
	output logic        fire_has_args,
	output logic [2:0]  fire_slot,
	output logic [15:0] query_rate,
	output logic [15:0] active_mask
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// table read/write paths between sequencer and storage
	logic [IDX_W-1:0]                 rd_idx;
	logic [IDX_W-1:0]                 wr_idx;
	pss_pkg::entry_t                  rd_ent;
	pss_pkg::tbl_wr_t                 wr;
	logic [pss_pkg::ACTIVE_W-1:0]     tbl_mask;

	// shared per-entry unit
	pss_pkg::step_req_t               step_req;
	pss_pkg::step_res_t               step_res;

	pss_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_idx      (rd_idx),
		.rd_ent      (rd_ent),
		.wr_idx      (wr_idx),
		.wr          (wr),
		.active_mask (tbl_mask)
	);

	// one compare/countdown unit, reused for every entry of the walk
	pss_step_unit u_step (
		.ent (rd_ent),
		.req (step_req),
		.res (step_res)
	);

	pss_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ARG_SLOTS    (ARG_SLOTS),
		.COMMANDS     (COMMANDS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.strm_id       (strm_id),
		.rate          (rate),
		.cmd_found     (cmd_found),
		.cmd_sel       (cmd_sel),
		.has_args      (has_args),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.fire_id       (fire_id),
		.fire_cmd      (fire_cmd),
		.fire_has_args (fire_has_args),
		.fire_slot     (fire_slot),
		.query_rate    (query_rate),
		.active_mask   (active_mask),
		.rd_idx        (rd_idx),
		.rd_ent        (rd_ent),
		.wr_idx        (wr_idx),
		.wr            (wr),
		.tbl_mask      (tbl_mask),
		.step_req      (step_req),
		.step_res      (step_res)
	);

endmodule

@@ test/pss_stream_checker.sv @@
// Checker for the periodic stream scheduler: watches both request channels,
// keeps its own copy of the stream table and compares every result.
// Depends on pss_pkg for the kind and status codes and the mask reset value.
module pss_stream_checker #(
	parameter int TABLE_ENTRIES = 4,
	parameter int ARG_SLOTS     = 8,
	parameter int COMMANDS      = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [14:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [7:0]  strm_id,
	input  logic [15:0] rate,
	input  logic        cmd_found,
	input  logic [3:0]  cmd_sel,
	input  logic        has_args,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  status,
	input  logic [3:0]  fire_id,
	input  logic [3:0]  fire_cmd,
	input  logic        fire_has_args,
	input  logic [2:0]  fire_slot,
	input  logic [15:0] query_rate,
	input  logic [15:0] active_mask,
	output int          mismatches,
	output int          backlog
);

	typedef struct packed {
		pss_pkg::status_t status;
		logic [3:0]  fire_id;
		logic [3:0]  fire_cmd;
		logic        fire_has_args;
		logic [2:0]  fire_slot;
		logic [15:0] query_rate;
		logic [15:0] active_mask;
	} sched_result_t;

	// shadow stream table; an id of zero marks a free entry
	logic [3:0]           st_id     [TABLE_ENTRIES];
	logic [3:0]           st_cmd    [TABLE_ENTRIES];
	logic [15:0]          st_rate   [TABLE_ENTRIES];
	logic [15:0]          st_cd     [TABLE_ENTRIES];
	logic [7:0]           st_queued [TABLE_ENTRIES];
	logic                 st_args   [TABLE_ENTRIES];
	logic [2:0]           st_slot   [TABLE_ENTRIES];
	logic [ARG_SLOTS-1:0] slot_used;
	logic [14:0]          streamable;

	sched_result_t awaited_results[$];
	sched_result_t want;

	function automatic int locate(input logic [7:0] sid);
		int i;
		int hit;
		hit = -1;
		for (i = TABLE_ENTRIES - 1; i >= 0; i--)
			if (st_id[i] != 4'd0 && {4'd0, st_id[i]} == sid)
				hit = i;
		return hit;
	endfunction

	function automatic void drop_entry(input int e);
		if (st_args[e])
			slot_used[st_slot[e]] = 1'b0;
		st_id[e] = 4'd0;
	endfunction

	function automatic sched_result_t stream_view(input int e);
		sched_result_t v;
		v = '0;
		v.status        = pss_pkg::STS_OK;
		v.fire_id       = st_id[e];
		v.fire_cmd      = st_cmd[e];
		v.fire_has_args = st_args[e];
		v.fire_slot     = st_args[e] ? st_slot[e] : 3'd0;
		v.query_rate    = st_rate[e];
		return v;
	endfunction

	// Apply one request to the shadow table and return the result it should give.
	function automatic sched_result_t schedule_step(input logic [2:0] k, input logic [7:0] sid,
			input logic [15:0] r_in, input logic found, input logic [3:0] cmd,
			input logic args);
		sched_result_t res;
		int i;
		int e;
		int free_e;
		int slot;
		logic [15:0] r;
		logic [15:0] cd;
		res = '0;
		res.status = pss_pkg::STS_OK;
		case (k)
		pss_pkg::K_ADD: begin
			r = (r_in == 16'd0) ? 16'd1 : r_in;
			cd = r;
			e = locate(sid);
			free_e = -1;
			slot = -1;
			for (i = TABLE_ENTRIES - 1; i >= 0; i--)
				if (st_id[i] == 4'd0)
					free_e = i;
			// the last active entry with the same rate lends its countdown
			for (i = 0; i < TABLE_ENTRIES; i++)
				if (st_id[i] != 4'd0 && st_rate[i] == r)
					cd = st_cd[i];
			for (i = ARG_SLOTS - 1; i >= 0; i--)
				if (!slot_used[i])
					slot = i;
			if (!found || cmd >= COMMANDS)
				res.status = pss_pkg::STS_UNKNOWN_CMD;
			else if (!streamable[cmd])
				res.status = pss_pkg::STS_NOT_STREAM;
			else if (sid == 8'd0)
				res.status = pss_pkg::STS_ID_ZERO;
			else if (sid > 8'd15)
				res.status = pss_pkg::STS_ID_INVALID;
			else if (e >= 0)
				res.status = pss_pkg::STS_IN_USE;
			else if (free_e < 0)
				res.status = pss_pkg::STS_FULL;
			else if (args && slot < 0)
				res.status = pss_pkg::STS_NO_SLOT;
			else begin
				st_id[free_e]     = sid[3:0];
				st_cmd[free_e]    = cmd;
				st_rate[free_e]   = r;
				st_cd[free_e]     = cd;
				st_queued[free_e] = 8'd0;
				st_args[free_e]   = args;
				st_slot[free_e]   = args ? 3'(slot) : 3'd0;
				if (args)
					slot_used[slot] = 1'b1;
			end
		end
		pss_pkg::K_REMOVE: begin
			e = locate(sid);
			if (sid == 8'd0)
				res.status = pss_pkg::STS_ID_ZERO;
			else if (e < 0)
				res.status = pss_pkg::STS_NOT_FOUND;
			else if (!found || cmd != st_cmd[e])
				res.status = pss_pkg::STS_MISMATCH;
			else
				drop_entry(e);
		end
		pss_pkg::K_TICK: begin
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (st_id[i] != 4'd0) begin
					st_cd[i] = st_cd[i] - 16'd1;
					if (st_cd[i] == 16'd0) begin
						st_queued[i] = st_queued[i] + 8'd1;
						st_cd[i] = st_rate[i];
					end
				end
			end
		end
		pss_pkg::K_POLL: begin
			e = -1;
			for (i = TABLE_ENTRIES - 1; i >= 0; i--)
				if (st_id[i] != 4'd0 && st_queued[i] != 8'd0)
					e = i;
			if (e < 0)
				res.status = pss_pkg::STS_NOTHING_DUE;
			else begin
				st_queued[e] = st_queued[e] - 8'd1;
				res = stream_view(e);
			end
		end
		pss_pkg::K_QUERY: begin
			e = locate(sid);
			if (sid == 8'd0)
				res.status = pss_pkg::STS_ID_ZERO;
			else if (e < 0)
				res.status = pss_pkg::STS_NOT_FOUND;
			else
				res = stream_view(e);
		end
		pss_pkg::K_FAIL: begin
			e = locate(sid);
			if (sid == 8'd0)
				res.status = pss_pkg::STS_ID_ZERO;
			else if (e < 0)
				res.status = pss_pkg::STS_NOT_FOUND;
			else
				drop_entry(e);
		end
		default: ;
		endcase
		for (i = 0; i < TABLE_ENTRIES; i++)
			if (st_id[i] != 4'd0)
				res.active_mask[st_id[i]] = 1'b1;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				st_id[i]     = 4'd0;
				st_cmd[i]    = 4'd0;
				st_rate[i]   = 16'd0;
				st_cd[i]     = 16'd0;
				st_queued[i] = 8'd0;
				st_args[i]   = 1'b0;
				st_slot[i]   = 3'd0;
			end
			slot_used  = '0;
			streamable = pss_pkg::MASK_RESET;
			awaited_results.delete();
			mismatches = 0;
			backlog <= 0;
		end else begin
			// results first: nothing taken at this edge can already be answered
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with none awaited, status %0h actual mask %0h",
						$time, status, active_mask);
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("fire_id", 16'(want.fire_id), 16'(fire_id));
					check_field("fire_cmd", 16'(want.fire_cmd), 16'(fire_cmd));
					check_field("fire_has_args", 16'(want.fire_has_args), 16'(fire_has_args));
					check_field("fire_slot", 16'(want.fire_slot), 16'(fire_slot));
					check_field("query_rate", want.query_rate, query_rate);
					check_field("active_mask", want.active_mask, active_mask);
				end
			end
			if (cfg_we)
				streamable = cfg_wdata;
			if (in_valid && in_ready)
				awaited_results.push_back(schedule_step(kind, strm_id, rate, cmd_found,
					cmd_sel, has_args));
			backlog <= awaited_results.size();
		end
	end

endmodule

@@ test/periodic_stream_scheduler_top_tb.sv @@
// Testbench top for the periodic stream scheduler: clock, reset, requests and
// the final verdict. Depends on pss_pkg, the block and pss_stream_checker.
module periodic_stream_scheduler_top_tb;

	// kinds outside the defined set; the block must answer them with ok
	localparam logic [2:0] K_SPARE_A = 3'd6;
	localparam logic [2:0] K_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [14:0] cfg_wdata = pss_pkg::MASK_RESET;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [2:0]  kind      = 3'd0;
	logic [7:0]  strm_id   = 8'd0;
	logic [15:0] rate      = 16'd0;
	logic        cmd_found = 1'b0;
	logic [3:0]  cmd_sel   = 4'd0;
	logic        has_args  = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  status;
	logic [3:0]  fire_id;
	logic [3:0]  fire_cmd;
	logic        fire_has_args;
	logic [2:0]  fire_slot;
	logic [15:0] query_rate;
	logic [15:0] active_mask;

	int mismatches;
	int backlog;
	int cycle_count   = 0;
	int send_idle_pct = 15;
	int recv_idle_pct = 78;

	// a streamable command chosen per stream id so that adds and removes of
	// one id agree on the command most of the time
	logic [3:0]  cmd_for_id [16];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	periodic_stream_scheduler_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.strm_id       (strm_id),
		.rate          (rate),
		.cmd_found     (cmd_found),
		.cmd_sel       (cmd_sel),
		.has_args      (has_args),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.fire_id       (fire_id),
		.fire_cmd      (fire_cmd),
		.fire_has_args (fire_has_args),
		.fire_slot     (fire_slot),
		.query_rate    (query_rate),
		.active_mask   (active_mask)
	);

	pss_stream_checker stream_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.strm_id       (strm_id),
		.rate          (rate),
		.cmd_found     (cmd_found),
		.cmd_sel       (cmd_sel),
		.has_args      (has_args),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.fire_id       (fire_id),
		.fire_cmd      (fire_cmd),
		.fire_has_args (fire_has_args),
		.fire_slot     (fire_slot),
		.query_rate    (query_rate),
		.active_mask   (active_mask),
		.mismatches    (mismatches),
		.backlog       (backlog)
	);

	// Stall the result side at random; a percentage of zero keeps ready high.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Watchdog: end the run with an error verdict once the cycle limit is reached.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("periodic_stream_scheduler_top_tb: done, errors");
			$finish;
		end
	end

	function automatic logic [3:0] pick_streamable(input logic [14:0] m);
		logic [3:0] c;
		c = 4'($urandom_range(0, 14));
		if (m != 15'd0)
			while (!m[c])
				c = 4'($urandom_range(0, 14));
		return c;
	endfunction

	// Present one request: idle at random first, then hold valid and payload
	// until the block takes it. Valid is left high on return so back-to-back
	// requests need no second assignment in one step.
	task automatic issue_request(input logic [2:0] k, input logic [7:0] sid,
			input logic [15:0] r, input logic found, input logic [3:0] cmd,
			input logic args);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		strm_id   <= sid;
		rate      <= r;
		cmd_found <= found;
		cmd_sel   <= cmd;
		has_args  <= args;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait out every awaited result, then give the block time to
	// finish its last commit.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Write the streamable mask only while the block is idle.
	task automatic write_mask(input logic [14:0] m);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int i = 0; i < 16; i++)
			cmd_for_id[i] = pick_streamable(m);
	endtask

	// Mostly well-formed traffic on a small id set so that adds, removes and
	// lookups keep hitting live streams; a little noise on id, command and kind.
	task automatic random_request();
		int pick;
		int rsel;
		logic [7:0]  sid;
		logic [15:0] r;
		logic [3:0]  c;
		logic [2:0]  k;
		logic        found;
		pick = $urandom_range(0, 199);
		sid = 8'($urandom_range(1, 6));
		if ($urandom_range(0, 15) == 0)
			sid = 8'($urandom_range(0, 15));
		if ($urandom_range(0, 39) == 0)
			sid = 8'($urandom);
		c = cmd_for_id[sid[3:0]];
		if ($urandom_range(0, 19) == 0)
			c = 4'($urandom);
		found = ($urandom_range(0, 29) != 0);
		// small rates make streams fire often and share countdowns
		rsel = $urandom_range(0, 19);
		if (rsel < 2)
			r = 16'd0;
		else if (rsel == 2)
			r = 16'hffff;
		else if (rsel == 3)
			r = 16'($urandom);
		else
			r = 16'($urandom_range(1, 4));
		if (pick < 50)
			k = pss_pkg::K_ADD;
		else if (pick < 110)
			k = pss_pkg::K_TICK;
		else if (pick < 135)
			k = pss_pkg::K_POLL;
		else if (pick < 155)
			k = pss_pkg::K_REMOVE;
		else if (pick < 175)
			k = pss_pkg::K_QUERY;
		else if (pick < 196)
			k = pss_pkg::K_FAIL;
		else
			k = (pick[0]) ? K_SPARE_B : K_SPARE_A;
		issue_request(k, sid, r, found, c, 1'($urandom));
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			cmd_for_id[i] = pick_streamable(pss_pkg::MASK_RESET);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset mask (commands 3 and 7 to 11 streamable).
		// Reject paths of add, in order of precedence.
		issue_request(pss_pkg::K_ADD, 8'd1, 16'd5, 1'b0, 4'd3, 1'b0);     // unknown command
		issue_request(pss_pkg::K_ADD, 8'd1, 16'd5, 1'b1, 4'd15, 1'b0);    // index past the table
		issue_request(pss_pkg::K_ADD, 8'd1, 16'd5, 1'b1, 4'd0, 1'b0);     // not streamable
		issue_request(pss_pkg::K_ADD, 8'd0, 16'd5, 1'b1, 4'd3, 1'b0);     // id zero
		issue_request(pss_pkg::K_ADD, 8'd16, 16'd5, 1'b1, 4'd3, 1'b0);    // id just past 15
		issue_request(pss_pkg::K_ADD, 8'd255, 16'd5, 1'b1, 4'd3, 1'b0);   // id at its top
		// fill the table: a zero rate runs as one, the next rate-one stream shares
		// its countdown, and the widest rate sits beside them
		issue_request(pss_pkg::K_ADD, 8'd1, 16'd0, 1'b1, 4'd3, 1'b1);
		issue_request(pss_pkg::K_ADD, 8'd1, 16'd2, 1'b1, 4'd3, 1'b0);     // in use
		issue_request(pss_pkg::K_ADD, 8'd15, 16'hffff, 1'b1, 4'd11, 1'b0);
		issue_request(pss_pkg::K_ADD, 8'd2, 16'd1, 1'b1, 4'd7, 1'b1);
		issue_request(pss_pkg::K_ADD, 8'd3, 16'd2, 1'b1, 4'd8, 1'b1);
		issue_request(pss_pkg::K_ADD, 8'd4, 16'd3, 1'b1, 4'd9, 1'b0);     // table full
		issue_request(pss_pkg::K_TICK, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_POLL, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_POLL, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_POLL, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);    // nothing due
		issue_request(pss_pkg::K_QUERY, 8'd15, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_QUERY, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_QUERY, 8'd5, 16'd0, 1'b0, 4'd0, 1'b0);
		// remove: wrong command, unknown command, then the real one
		issue_request(pss_pkg::K_REMOVE, 8'd1, 16'd0, 1'b1, 4'd4, 1'b0);
		issue_request(pss_pkg::K_REMOVE, 8'd1, 16'd0, 1'b0, 4'd3, 1'b0);
		issue_request(pss_pkg::K_REMOVE, 8'd1, 16'd0, 1'b1, 4'd3, 1'b0);
		issue_request(pss_pkg::K_REMOVE, 8'd0, 16'd0, 1'b1, 4'd3, 1'b0);
		issue_request(pss_pkg::K_FAIL, 8'd2, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_FAIL, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_FAIL, 8'd200, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(K_SPARE_A, 8'd3, 16'd9, 1'b1, 4'd8, 1'b1);
		issue_request(K_SPARE_B, 8'd3, 16'd9, 1'b1, 4'd8, 1'b1);

		// Phase one: every command streamable, slow receiver.
		write_mask(15'h7fff);
		repeat (420) random_request();
		// No command streamable: adds all bounce, the rest drains the table.
		write_mask(15'h0000);
		repeat (30) random_request();

		// Phase two: slow sender, random mask.
		send_idle_pct = 78;
		recv_idle_pct = 15;
		write_mask(15'($urandom));
		repeat (420) random_request();

		// Phase three: no idling. Empty the table, then let one rate-one stream
		// run long enough for its queued count to wrap past 255.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_mask(pss_pkg::MASK_RESET);
		for (int i = 1; i < 16; i++)
			issue_request(pss_pkg::K_FAIL, 8'(i), 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_ADD, 8'd9, 16'd1, 1'b1, cmd_for_id[9], 1'b1);
		repeat (258) issue_request(pss_pkg::K_TICK, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		repeat (3) issue_request(pss_pkg::K_POLL, 8'd0, 16'd0, 1'b0, 4'd0, 1'b0);
		issue_request(pss_pkg::K_QUERY, 8'd9, 16'd0, 1'b0, 4'd0, 1'b0);
		repeat (150) random_request();

		// Drain and give the verdict.
		settle();
		if (mismatches == 0)
			$display("periodic_stream_scheduler_top_tb: done, clean");
		else
			$display("periodic_stream_scheduler_top_tb: done, errors");
		$finish;
	end

endmodule
